[rtl/core/gauge_ratio_rain_scaler_top_macros.svh]
// assertion macros used by the checker file grrs_checker.sv
`ifndef GAUGE_RATIO_RAIN_SCALER_TOP_MACROS_SVH
`define GAUGE_RATIO_RAIN_SCALER_TOP_MACROS_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define GRRS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("grrs assertion failed");

// next-cycle implication
`define GRRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("grrs assertion failed");

`endif

[rtl/core/grrs_pkg.sv]
package grrs_pkg;

    localparam int QUARTERS = 4;

    typedef enum logic [1:0] {
        CASE_GAUGE_ZERO = 2'd0,
        CASE_EVEN_SPLIT = 2'd1,
        CASE_RATIO      = 2'd2
    } t_case;

    typedef struct packed {
        logic  valid;
        t_case code;
    } t_ctl;

endpackage

[rtl/core/grrs_in_if.sv]
interface grrs_in_if #(
    parameter int SAMPLE_BITS = 20
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] radar_q1;
    logic [SAMPLE_BITS-1:0] radar_q2;
    logic [SAMPLE_BITS-1:0] radar_q3;
    logic [SAMPLE_BITS-1:0] radar_q4;
    logic [SAMPLE_BITS-1:0] gauge_hour;

    modport source (
        output valid, radar_q1, radar_q2, radar_q3, radar_q4, gauge_hour,
        input  ready
    );

    modport sink (
        input  valid, radar_q1, radar_q2, radar_q3, radar_q4, gauge_hour,
        output ready
    );
endinterface

[rtl/core/grrs_out_if.sv]
interface grrs_out_if #(
    parameter int SAMPLE_BITS = 20
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] scaled_q1;
    logic [SAMPLE_BITS-1:0] scaled_q2;
    logic [SAMPLE_BITS-1:0] scaled_q3;
    logic [SAMPLE_BITS-1:0] scaled_q4;
    logic [1:0]             case_code;

    modport source (
        output valid, scaled_q1, scaled_q2, scaled_q3, scaled_q4, case_code,
        input  ready
    );

    modport sink (
        input  valid, scaled_q1, scaled_q2, scaled_q3, scaled_q4, case_code,
        output ready
    );
endinterface

[rtl/core/grrs_div.sv]
module grrs_div #(
    parameter int NUM_W  = 36,
    parameter int DEN_W  = 22,
    parameter int SIDE_W = 100
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  grrs_pkg::t_ctl     i_ctl,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [SIDE_W-1:0]  i_side,
    output grrs_pkg::t_ctl     o_ctl,
    output logic [NUM_W-1:0]   o_quo,
    output logic [SIDE_W-1:0]  o_side
);

    // one restoring step per stage, numerator consumed msb first
    grrs_pkg::t_ctl    r_ctl  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [NUM_W-1:0]  r_num  [NUM_W];
    logic [NUM_W-1:0]  r_quo  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        grrs_pkg::t_ctl    w_ctl_in;
        logic [DEN_W-1:0]  w_rem_in;
        logic [DEN_W-1:0]  w_den_in;
        logic [NUM_W-1:0]  w_num_in;
        logic [NUM_W-1:0]  w_quo_in;
        logic [SIDE_W-1:0] w_side_in;
        logic [DEN_W:0]    n_trial;
        logic [DEN_W:0]    n_diff;
        logic              n_bit;

        if (k == 0) begin : g_first
            assign w_ctl_in  = i_ctl;
            assign w_rem_in  = '0;
            assign w_den_in  = i_den;
            assign w_num_in  = i_num;
            assign w_quo_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_ctl_in  = r_ctl[k-1];
            assign w_rem_in  = r_rem[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_num_in  = r_num[k-1];
            assign w_quo_in  = r_quo[k-1];
            assign w_side_in = r_side[k-1];
        end

        assign n_trial = {w_rem_in, w_num_in[NUM_W-1]};
        assign n_diff  = n_trial - {1'b0, w_den_in};
        assign n_bit   = (n_trial >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ctl[k] <= '0;
            end else if (i_en) begin
                r_ctl[k] <= w_ctl_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_bit ? n_diff[DEN_W-1:0] : n_trial[DEN_W-1:0];
                r_den[k]  <= w_den_in;
                r_num[k]  <= {w_num_in[NUM_W-2:0], 1'b0};
                r_quo[k]  <= {w_quo_in[NUM_W-2:0], n_bit};
                r_side[k] <= w_side_in;
            end
        end
    end

    assign o_ctl  = r_ctl[NUM_W-1];
    assign o_quo  = r_quo[NUM_W-1];
    assign o_side = r_side[NUM_W-1];

endmodule

[rtl/core/grrs_lane.sv]
module grrs_lane #(
    parameter int SAMPLE_BITS = 20,
    parameter int WEIGHT_FRAC = 16
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [SAMPLE_BITS-1:0]           i_radar,
    input  logic [SAMPLE_BITS+WEIGHT_FRAC-1:0] i_weight,
    output logic [SAMPLE_BITS-1:0]           o_scaled
);

    localparam int LO_W = SAMPLE_BITS + WEIGHT_FRAC;

    logic [SAMPLE_BITS-1:0] w_hi_weight;
    logic [WEIGHT_FRAC-1:0] w_lo_weight;
    logic [SAMPLE_BITS-1:0] n_hi;
    logic [LO_W-1:0]        n_lo;
    logic [SAMPLE_BITS-1:0] r_hi;
    logic [SAMPLE_BITS-1:0] r_lo;
    logic [SAMPLE_BITS-1:0] r_scaled;

    // weight split at the binary point: integer part times radar lands unshifted,
    // only the fraction product needs the shift; sums wrap at the field width
    assign w_hi_weight = i_weight[LO_W-1:WEIGHT_FRAC];
    assign w_lo_weight = i_weight[WEIGHT_FRAC-1:0];
    assign n_hi        = i_radar * w_hi_weight;
    assign n_lo        = LO_W'(i_radar) * LO_W'(w_lo_weight);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hi     <= n_hi;
            r_lo     <= n_lo[LO_W-1:WEIGHT_FRAC];
            r_scaled <= r_hi + r_lo;
        end
    end

    assign o_scaled = r_scaled;

endmodule

[rtl/core/grrs_merge.sv]
module grrs_merge #(
    parameter int SAMPLE_BITS = 20
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  grrs_pkg::t_ctl         i_ctl,
    input  logic [SAMPLE_BITS-1:0] i_even,
    input  logic [SAMPLE_BITS-1:0] i_scaled [grrs_pkg::QUARTERS],
    output logic                   o_en,
    grrs_out_if.source             o_out
);

    logic                   r_valid;
    grrs_pkg::t_case        r_code;
    logic [SAMPLE_BITS-1:0] r_scaled [grrs_pkg::QUARTERS];
    logic [SAMPLE_BITS-1:0] n_scaled [grrs_pkg::QUARTERS];

    // pipeline moves whenever the output slot is free or being emptied
    assign o_en = !r_valid || o_out.ready;

    always_comb begin
        for (int k = 0; k < grrs_pkg::QUARTERS; k++) begin
            case (i_ctl.code)
                grrs_pkg::CASE_GAUGE_ZERO: n_scaled[k] = '0;
                grrs_pkg::CASE_EVEN_SPLIT: n_scaled[k] = i_even;
                default:                   n_scaled[k] = i_scaled[k];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_code   <= i_ctl.code;
            r_scaled <= n_scaled;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.scaled_q1 = r_scaled[0];
    assign o_out.scaled_q2 = r_scaled[1];
    assign o_out.scaled_q3 = r_scaled[2];
    assign o_out.scaled_q4 = r_scaled[3];
    assign o_out.case_code = r_code;

endmodule

[rtl/core/gauge_ratio_rain_scaler_top.sv]
// channel   dir   payload                                     handshake
// i_in      in    radar_q1..radar_q4, gauge_hour              valid / ready
// o_out     out   scaled_q1..scaled_q4, case_code             valid / ready
//
// one cell enters per cycle unless the pipeline holds; the divider chain
// resolves one quotient bit per stage
// the whole pipeline advances together; it holds only while a result sits in
// the output register and o_out.ready is low, and i_in.ready is low then too
// reset clears only the stage valid bits and the control words that carry them
module gauge_ratio_rain_scaler_top #(
    parameter int SAMPLE_BITS = 20,
    parameter int WEIGHT_FRAC = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    grrs_in_if.sink    i_in,
    grrs_out_if.source o_out
);

    localparam int NUM_W  = SAMPLE_BITS + WEIGHT_FRAC;
    localparam int DEN_W  = SAMPLE_BITS + 2;
    localparam int SIDE_W = (grrs_pkg::QUARTERS + 1) * SAMPLE_BITS;

    logic                   w_en;
    logic [DEN_W-1:0]       n_sum;
    grrs_pkg::t_case        n_code;
    grrs_pkg::t_ctl         r_s0_ctl;
    logic [NUM_W-1:0]       r_s0_num;
    logic [DEN_W-1:0]       r_s0_den;
    logic [SIDE_W-1:0]      r_s0_side;
    grrs_pkg::t_ctl         w_div_ctl;
    logic [NUM_W-1:0]       w_div_quo;
    logic [SIDE_W-1:0]      w_div_side;
    grrs_pkg::t_ctl         r_l1_ctl;
    grrs_pkg::t_ctl         r_l2_ctl;
    logic [SAMPLE_BITS-1:0] r_l1_even;
    logic [SAMPLE_BITS-1:0] r_l2_even;
    logic [SAMPLE_BITS-1:0] w_scaled [grrs_pkg::QUARTERS];

    assign i_in.ready = w_en;

    assign n_sum = DEN_W'(i_in.radar_q1) + DEN_W'(i_in.radar_q2)
                 + DEN_W'(i_in.radar_q3) + DEN_W'(i_in.radar_q4);

    always_comb begin
        if (i_in.gauge_hour == '0) begin
            n_code = grrs_pkg::CASE_GAUGE_ZERO;
        end else if ((i_in.radar_q1 | i_in.radar_q2 | i_in.radar_q3 | i_in.radar_q4) == '0) begin
            n_code = grrs_pkg::CASE_EVEN_SPLIT;
        end else begin
            n_code = grrs_pkg::CASE_RATIO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_ctl <= '0;
            r_l1_ctl <= '0;
            r_l2_ctl <= '0;
        end else if (w_en) begin
            r_s0_ctl <= '{valid: i_in.valid, code: n_code};
            r_l1_ctl <= w_div_ctl;
            r_l2_ctl <= r_l1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_num  <= {i_in.gauge_hour, {WEIGHT_FRAC{1'b0}}};
            r_s0_den  <= n_sum;
            r_s0_side <= {i_in.gauge_hour >> 2, i_in.radar_q4, i_in.radar_q3,
                          i_in.radar_q2, i_in.radar_q1};
            r_l1_even <= w_div_side[grrs_pkg::QUARTERS*SAMPLE_BITS +: SAMPLE_BITS];
            r_l2_even <= r_l1_even;
        end
    end

    grrs_div #(
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .SIDE_W (SIDE_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_ctl   (r_s0_ctl),
        .i_num   (r_s0_num),
        .i_den   (r_s0_den),
        .i_side  (r_s0_side),
        .o_ctl   (w_div_ctl),
        .o_quo   (w_div_quo),
        .o_side  (w_div_side)
    );

    for (genvar k = 0; k < grrs_pkg::QUARTERS; k++) begin : g_lane
        grrs_lane #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .WEIGHT_FRAC (WEIGHT_FRAC)
        ) u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_radar  (w_div_side[k*SAMPLE_BITS +: SAMPLE_BITS]),
            .i_weight (w_div_quo),
            .o_scaled (w_scaled[k])
        );
    end

    grrs_merge #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (r_l2_ctl),
        .i_even   (r_l2_even),
        .i_scaled (w_scaled),
        .o_en     (w_en),
        .o_out    (o_out)
    );

endmodule

[rtl/core/grrs_checker.sv]
`include "gauge_ratio_rain_scaler_top_macros.svh"

module grrs_checker #(
    parameter int SAMPLE_BITS = 20
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic [SAMPLE_BITS-1:0] i_scaled_q1,
    input logic [SAMPLE_BITS-1:0] i_scaled_q2,
    input logic [SAMPLE_BITS-1:0] i_scaled_q3,
    input logic [SAMPLE_BITS-1:0] i_scaled_q4,
    input logic [1:0]             i_case_code
);

    // a stalled result keeps its payload
    `GRRS_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_scaled_q1) && $stable(i_scaled_q2) && $stable(i_scaled_q3) && $stable(i_scaled_q4) && $stable(i_case_code))

    // an empty output slot never refuses a request
    `GRRS_ASSERT_IMPL(a_ready_when_empty, !i_out_valid, i_in_ready)

    // gauge-zero results carry all-zero data
    `GRRS_ASSERT_IMPL(a_gauge_zero_data, i_out_valid && i_case_code == grrs_pkg::CASE_GAUGE_ZERO, i_scaled_q1 == '0 && i_scaled_q2 == '0 && i_scaled_q3 == '0 && i_scaled_q4 == '0)

    // even split gives four equal quarters
    `GRRS_ASSERT_IMPL(a_even_split_equal, i_out_valid && i_case_code == grrs_pkg::CASE_EVEN_SPLIT, i_scaled_q1 == i_scaled_q2 && i_scaled_q2 == i_scaled_q3 && i_scaled_q3 == i_scaled_q4)

    // stalled output blocks new requests
    `GRRS_ASSERT_IMPL(a_stall_blocks_in, i_out_valid && !i_out_ready, !i_in_ready)

endmodule

bind gauge_ratio_rain_scaler_top grrs_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_grrs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_scaled_q1 (o_out.scaled_q1),
    .i_scaled_q2 (o_out.scaled_q2),
    .i_scaled_q3 (o_out.scaled_q3),
    .i_scaled_q4 (o_out.scaled_q4),
    .i_case_code (o_out.case_code)
);

[test/tb.sv]
module tb;

    localparam int SAMPLE_BITS = 20;
    localparam int WEIGHT_FRAC = 16;
    localparam int LATENCY     = SAMPLE_BITS + WEIGHT_FRAC + 4;
    localparam int STALL_LIMIT = 2000;
    localparam int CELL_COUNT  = 550;
    localparam int PRINT_LIMIT = 30;

    typedef logic [SAMPLE_BITS-1:0] t_sample;

    typedef struct packed {
        t_sample                          gauge;
        t_sample [grrs_pkg::QUARTERS-1:0] radar;
    } t_rain_cell;

    typedef struct packed {
        grrs_pkg::t_case                  code;
        t_sample [grrs_pkg::QUARTERS-1:0] scaled;
    } t_scaled_cell;

    localparam t_sample SAMPLE_MAX = '1;

    logic i_clk;
    logic i_rst_n;

    grrs_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    grrs_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) out_ch ();

    gauge_ratio_rain_scaler_top #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .WEIGHT_FRAC(WEIGHT_FRAC)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_scaled_cell expected_scaled[$];
    int           error_count = 0;
    int           hold_cycles = 0;
    int           idle_cycles = 0;
    bit           gaps_on     = 1'b1;
    bit           stalls_on   = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // gauge-weighted calibration of one cell
    function automatic t_scaled_cell scale_cell(t_rain_cell c);
        t_scaled_cell r;
        logic [63:0]  total;
        logic [63:0]  weight;
        logic [63:0]  prod;
        int           k;
        total = '0;
        for (k = 0; k < grrs_pkg::QUARTERS; k++)
            total = total + 64'(c.radar[k]);
        if (c.gauge == '0) begin
            r.code = grrs_pkg::CASE_GAUGE_ZERO;
            for (k = 0; k < grrs_pkg::QUARTERS; k++)
                r.scaled[k] = '0;
        end else if (total == '0) begin
            r.code = grrs_pkg::CASE_EVEN_SPLIT;
            for (k = 0; k < grrs_pkg::QUARTERS; k++)
                r.scaled[k] = c.gauge >> 2;
        end else begin
            weight = (64'(c.gauge) << WEIGHT_FRAC) / total;
            r.code = grrs_pkg::CASE_RATIO;
            for (k = 0; k < grrs_pkg::QUARTERS; k++) begin
                prod        = 64'(c.radar[k]) * weight;
                r.scaled[k] = t_sample'(prod >> WEIGHT_FRAC);
            end
        end
        return r;
    endfunction

    function automatic t_rain_cell make_cell(t_sample q1, t_sample q2, t_sample q3,
                                             t_sample q4, t_sample g);
        t_rain_cell c;
        c.radar[0] = q1;
        c.radar[1] = q2;
        c.radar[2] = q3;
        c.radar[3] = q4;
        c.gauge    = g;
        return c;
    endfunction

    // random magnitude so small and large accumulations both show up
    function automatic t_sample rand_sample();
        return t_sample'($urandom()) >> $urandom_range(0, SAMPLE_BITS - 1);
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        if (error_count < PRINT_LIMIT)
            $display("mismatch %s: got %0d want %0d", what, got, want);
        error_count++;
    endtask

    task automatic send_cell(input t_rain_cell c);
        int gap;
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.radar_q1   <= c.radar[0];
        in_ch.radar_q2   <= c.radar[1];
        in_ch.radar_q3   <= c.radar[2];
        in_ch.radar_q4   <= c.radar[3];
        in_ch.gauge_hour <= c.gauge;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        expected_scaled.push_back(scale_cell(c));
    endtask

    task automatic test_gauge_zero();
        send_cell(make_cell(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, '0));
        send_cell(make_cell('0, '0, '0, '0, '0));
        send_cell(make_cell(20'd1, '0, 20'd777, SAMPLE_MAX, '0));
    endtask

    task automatic test_even_split();
        send_cell(make_cell('0, '0, '0, '0, 20'd1));
        send_cell(make_cell('0, '0, '0, '0, 20'd3));
        send_cell(make_cell('0, '0, '0, '0, 20'd4));
        send_cell(make_cell('0, '0, '0, '0, 20'hAAAAA));
        send_cell(make_cell('0, '0, '0, '0, SAMPLE_MAX));
    endtask

    task automatic test_ratio_scaling();
        send_cell(make_cell(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX));
        // largest weight: tiny radar, full gauge
        send_cell(make_cell(20'd1, '0, '0, '0, SAMPLE_MAX));
        // weight truncates to zero
        send_cell(make_cell('0, '0, '0, SAMPLE_MAX, 20'd1));
        send_cell(make_cell(20'd1234, '0, '0, '0, 20'd5678));
        send_cell(make_cell('0, 20'd1234, '0, '0, 20'd5678));
        send_cell(make_cell('0, '0, 20'd1234, '0, 20'd5678));
        send_cell(make_cell('0, '0, '0, 20'd1234, 20'd5678));
        send_cell(make_cell(20'd1, 20'd1, 20'd1, 20'd1, SAMPLE_MAX));
        send_cell(make_cell(20'd250, 20'd250, 20'd250, 20'd250, 20'd1000));
        send_cell(make_cell(SAMPLE_MAX, 20'd1, '0, '0, 20'h55555));
        send_cell(make_cell(20'h55555, 20'hAAAAA, 20'h0F0F0, 20'hF0F0F, 20'd3));
    endtask

    task automatic test_random_cells();
        t_rain_cell c;
        int         n;
        int         k;
        int         pick;
        for (n = 0; n < CELL_COUNT; n++) begin
            // phases with and without idling on either side
            if (n % 50 == 0) begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                stalls_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 9);
            for (k = 0; k < grrs_pkg::QUARTERS; k++)
                c.radar[k] = rand_sample();
            c.gauge = rand_sample();
            case (pick)
                0: c.gauge = '0;
                1: c.radar = '0;
                2: c.radar[$urandom_range(0, grrs_pkg::QUARTERS - 1)] = '0;
                3: begin
                    for (k = 0; k < grrs_pkg::QUARTERS; k++)
                        c.radar[k] = t_sample'($urandom());
                    c.gauge = t_sample'($urandom());
                end
                default: ;
            endcase
            send_cell(c);
        end
    endtask

    // result side: random stalls, compare with oldest prediction
    always @(posedge i_clk) begin
        t_scaled_cell                     want;
        t_sample [grrs_pkg::QUARTERS-1:0] got;
        int                               k;
        if (i_rst_n !== 1'b1) begin
            hold_cycles = 0;
            out_ch.ready <= 1'b0;
        end else if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (expected_scaled.size() == 0) begin
                report_mismatch("result with no request pending", 64'd0, 64'd0);
            end else begin
                want = expected_scaled.pop_front();
                got  = {out_ch.scaled_q4, out_ch.scaled_q3, out_ch.scaled_q2, out_ch.scaled_q1};
                for (k = 0; k < grrs_pkg::QUARTERS; k++)
                    if (got[k] !== want.scaled[k])
                        report_mismatch($sformatf("scaled_q%0d", k + 1),
                                        64'(got[k]), 64'(want.scaled[k]));
                if (out_ch.case_code !== want.code)
                    report_mismatch("case_code", 64'(out_ch.case_code), 64'(want.code));
            end
            hold_cycles = stalls_on ? $urandom_range(0, 5) : 0;
            out_ch.ready <= (hold_cycles == 0);
        end else if (hold_cycles > 0) begin
            hold_cycles--;
            out_ch.ready <= (hold_cycles == 0);
        end else begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        in_ch.valid      <= 1'b0;
        in_ch.radar_q1   <= '0;
        in_ch.radar_q2   <= '0;
        in_ch.radar_q3   <= '0;
        in_ch.radar_q4   <= '0;
        in_ch.gauge_hour <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_gauge_zero();
        test_even_split();
        test_ratio_scaling();
        test_random_cells();

        in_ch.valid <= 1'b0;
        while (expected_scaled.size() > 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
